### src/lru_key_value_cache_unit_assert.svh
// Assertion macros for the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LKV_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed")
`define LKV_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed")
`else
`define LKV_ASSERT_IMPL(label, clk, rst_n, prop)
`define LKV_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### src/lkv_pkg.sv
// Shared types and constants of the LRU key-value cache.
package lkv_pkg;
    localparam int unsigned ENTRIES_DEF = 16;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_req;
endpackage

### src/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache.
// Fully associative key-value store with least-recently-used replacement.
// Requests enter on the s_axis group: tuser is the op (0 get, 1 put),
// tdata holds key in bits 31:0 and value in bits 63:32.
// Each request gives one result on m_axis: tuser is hit, tdata is the
// value read (zero on a miss and on every put).
// The capacity register is written on the cfg channel; the user must do so
// while idle, as the block itself does not enforce it. A request passes a
// two-entry queue; the back end compares all keys in parallel in S_LOOK and
// updates ranks and storage and registers the result in S_EXEC, where it
// waits while the output register is full. It takes requests only in S_LOOK.
// Reset empties the store and sets the capacity to 16.
// If the receiver stalls, the result waits in the output register; the back
// end holds one more request and the queue two before s_axis_tready falls.
`include "lru_key_value_cache_unit_assert.svh"
module lru_key_value_cache_unit
    import lkv_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // key, value
    input  logic                 s_axis_tuser,  // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // read_value
    output logic                 m_axis_tuser,  // hit
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CAP_W-1:0]     i_cfg_data
);
    logic [CAP_W-1:0] r_cap;
    t_req in_req;
    t_req q_req;
    logic q_valid;
    logic q_ready;

    assign o_cfg_ready = 1'b1;
    assign in_req = '{op: s_axis_tuser, key: s_axis_tdata[31:0], value: s_axis_tdata[63:32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    lkv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_req(in_req),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(q_req)
    );

    lkv_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cap(r_cap),
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_hit(m_axis_tuser), .o_value(m_axis_tdata)
    );

    `LKV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata));
    `LKV_ASSERT_IMPL(a_put_zero, i_clk, i_rst_n,
        m_axis_tvalid |-> (m_axis_tuser || m_axis_tdata == '0));
endmodule

### src/lkv_front.sv
// Front end: accepts requests into a two-entry queue for the back end.
module lkv_front
    import lkv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_req  i_req,
    output logic  o_valid,
    input  logic  i_ready,
    output t_req  o_req
);
    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### src/lkv_back.sv
// Back end: matches keys, updates recency ranks and produces results.
module lkv_back
    import lkv_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CAP_W-1:0]  i_cap,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_req              i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_hit,
    output logic [VAL_W-1:0]  o_value
);
    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned OW = $clog2(ENTRIES + 1);

    typedef enum logic { S_LOOK, S_EXEC } t_state;

    t_state              r_state;
    t_req                r_req;
    logic [ENTRIES-1:0]  r_valid;
    logic [KEY_W-1:0]    r_key [ENTRIES];
    logic [VAL_W-1:0]    r_val [ENTRIES];
    logic [IW-1:0]       r_rank [ENTRIES];
    logic [OW-1:0]       r_occ;
    logic [ENTRIES-1:0]  r_match;
    logic                r_ovalid;
    logic                r_ohit;
    logic [VAL_W-1:0]    r_oval;

    logic                hit;
    logic [IW-1:0]       hidx;
    logic [IW-1:0]       oldidx;
    logic [IW-1:0]       freeidx;
    logic                have_free;
    logic [OW-1:0]       cap_eff;
    logic                full;
    logic [IW-1:0]       slot;
    logic [OW-1:0]       limit;
    logic                out_free;

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_LOOK);
    assign o_valid  = r_ovalid;
    assign o_hit    = r_ohit;
    assign o_value  = r_oval;

    always_comb begin
        hit = |r_match;
        hidx = '0;
        oldidx = '0;
        freeidx = '0;
        have_free = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) hidx = IW'(i);
            if (!r_valid[i]) begin
                freeidx = IW'(i);
                have_free = 1'b1;
            end
            if (r_valid[i] && ({1'b0, r_rank[i]} == OW'(r_occ - OW'(1)))) oldidx = IW'(i);
        end
        if (i_cap == '0) cap_eff = OW'(1);
        else if (32'(i_cap) > ENTRIES) cap_eff = OW'(ENTRIES);
        else cap_eff = OW'(i_cap);
        full = (r_occ >= cap_eff) || !have_free;
        if (hit) begin
            slot = hidx;
            limit = {1'b0, r_rank[hidx]};
        end else if (full) begin
            slot = oldidx;
            limit = r_occ;
        end else begin
            slot = freeidx;
            limit = r_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOOK;
            r_valid  <= '0;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_state != S_EXEC) r_ovalid <= 1'b0;
            unique case (r_state)
                S_LOOK: begin
                    if (i_valid) begin
                        r_req <= i_req;
                        for (int i = 0; i < ENTRIES; i++) begin
                            r_match[i] <= r_valid[i] && (r_key[i] == i_req.key);
                        end
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ohit   <= hit;
                        r_oval   <= (hit && r_req.op == OP_GET) ? r_val[hidx] : '0;
                        r_state  <= S_LOOK;
                        if (hit || r_req.op == OP_PUT) begin
                            for (int i = 0; i < ENTRIES; i++) begin
                                if (r_valid[i] && IW'(i) != slot
                                        && {1'b0, r_rank[i]} < limit) begin
                                    r_rank[i] <= r_rank[i] + IW'(1);
                                end
                            end
                            r_rank[slot] <= '0;
                        end
                        if (r_req.op == OP_PUT) begin
                            r_val[slot] <= r_req.value;
                            if (!hit) begin
                                r_key[slot] <= r_req.key;
                                if (!full) begin
                                    r_valid[slot] <= 1'b1;
                                    r_occ <= r_occ + OW'(1);
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_LOOK;
            endcase
        end
    end
endmodule
